/* design/hfc_pkg.sv */
// Shared types, constants and helpers for the half float converter.
package hfc_pkg;

	typedef enum logic [1:0] {
		KIND_H2S = 2'd0,
		KIND_H2D = 2'd1,
		KIND_S2H = 2'd2,
		KIND_D2H = 2'd3
	} kind_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [63:0] operand;
	} hfc_in_t;

	typedef struct packed {
		logic [63:0] result;
		logic        half_is_nan;
		logic        half_is_inf;
	} hfc_out_t;

	// Source fields decoded in the first stage.
	typedef struct packed {
		logic        widen;
		logic        dbl;
		logic        neg;
		logic [10:0] exp;
		logic [9:0]  frac;
		logic        fzero;
		logic        emax;
		logic        hsub;
	} hfc_dec_t;

	localparam logic [15:0] HalfNan  = 16'h7E00;
	localparam logic [15:0] HalfMaxf = 16'h7BFF;
	localparam logic [15:0] HalfInf  = 16'h7C00;
	localparam logic [31:0] F32Nan   = 32'h7FC00000;
	localparam logic [63:0] F64Nan   = 64'h7FF8000000000000;

	// Shift count that puts the leading one of a half subnormal fraction at bit 10.
	function automatic logic [3:0] lead_shift(input logic [9:0] m);
		logic [3:0] n;
		n = 4'd0;
		for (int i = 0; i < 10; i++) begin
			if (m[i]) begin
				n = 4'(10 - i);
			end
		end
		return n;
	endfunction

endpackage

/* design/half_float_converter.sv */
// Top level of the half float converter: three stage pipeline.
// A beat accepted at a rising edge passes through the v_s1, v_s2 and v_s3 registers and shows
// its result with done high once it reaches v_s3. Throughput: one beat per cycle; busy is
// always low, since the receiver cannot stall. Reset clears all stage valid bits and
// the clamp_q register to zero; payload registers are not reset.
module half_float_converter import hfc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  hfc_in_t  operand_in,
	output logic     done,
	output hfc_out_t result_out,
	input  logic     cfg_valid,
	output logic     cfg_ready,
	input  logic     cfg_data
);
	logic        clamp_q;
	logic        v_s1, v_s2, v_s3;
	hfc_dec_t    dec_c, dec_s1, dec_s2;
	logic [10:0] exp_c, exp_s2;
	logic [9:0]  frac_c, frac_s2;
	hfc_out_t    out_c, out_s3;

	// The pipeline never stalls, so both handshakes are always open.
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clamp_q <= 1'b0;
		end else if (cfg_valid) begin
			clamp_q <= cfg_data;
		end
	end

	// Stage one decodes the source fields.
	hfc_decode u_dec (.in_item(operand_in), .dec(dec_c));
	// Stage two normalizes and rebiases.
	hfc_norm u_norm (.dec(dec_s1), .exp_out(exp_c), .frac_out(frac_c));
	// Stage three handles special values and packs the result.
	hfc_pack u_pack (
		.dec(dec_s2), .exp_in(exp_s2), .frac_in(frac_s2),
		.clamp(clamp_q), .out_item(out_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		dec_s1  <= dec_c;
		dec_s2  <= dec_s1;
		exp_s2  <= exp_c;
		frac_s2 <= frac_c;
		out_s3  <= out_c;
	end

	assign done       = v_s3;
	assign result_out = out_s3;

	// A result appears with done high once its beat has passed through v_s1, v_s2 and v_s3.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##3 done) else $error("result missing after accepted beat");
	// Flags never both set.
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(result_out.half_is_nan && result_out.half_is_inf))
		else $error("nan and inf flags both set");
	// Narrowed results stay within sixteen bits.
	a_narrow: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !dec_s2.widen) |=> (result_out.result[63:16] == 48'd0))
		else $error("narrowed result has high bits set");
endmodule

/* design/hfc_decode.sv */
// First stage: field extraction and classification of the source operand.
module hfc_decode import hfc_pkg::*; (
	input  hfc_in_t  in_item,
	output hfc_dec_t dec
);
	always_comb begin
		dec = '0;
		unique case (kind_t'(in_item.kind))
			KIND_H2S, KIND_H2D: begin
				dec.widen = 1'b1;
				dec.dbl   = in_item.kind[0];
				dec.neg   = in_item.operand[15];
				dec.exp   = {6'd0, in_item.operand[14:10]};
				dec.frac  = in_item.operand[9:0];
				dec.fzero = in_item.operand[9:0] == 10'd0;
				dec.emax  = in_item.operand[14:10] == 5'h1F;
				dec.hsub  = in_item.operand[14:10] == 5'd0;
			end
			KIND_S2H: begin
				dec.neg   = in_item.operand[31];
				dec.exp   = {3'd0, in_item.operand[30:23]};
				dec.frac  = in_item.operand[22:13];
				dec.fzero = in_item.operand[22:0] == 23'd0;
				dec.emax  = in_item.operand[30:23] == 8'hFF;
			end
			default: begin
				dec.dbl   = 1'b1;
				dec.neg   = in_item.operand[63];
				dec.exp   = in_item.operand[62:52];
				dec.frac  = in_item.operand[51:42];
				dec.fzero = in_item.operand[51:0] == 52'd0;
				dec.emax  = in_item.operand[62:52] == 11'h7FF;
			end
		endcase
	end
endmodule

/* design/hfc_norm.sv */
// Second stage: subnormal normalization and exponent rebias.
module hfc_norm import hfc_pkg::*; (
	input  hfc_dec_t    dec,
	output logic [10:0] exp_out,
	output logic [9:0]  frac_out
);
	logic [3:0]  sh;
	logic [10:0] mshift;
	always_comb begin
		sh     = lead_shift(dec.frac);
		mshift = {1'b0, dec.frac} << sh;
		exp_out  = dec.exp;
		frac_out = dec.frac;
		if (dec.widen) begin
			if (dec.hsub) begin
				exp_out  = (dec.dbl ? 11'd1009 : 11'd113) - {7'd0, sh};
				frac_out = mshift[9:0];
			end else begin
				exp_out = dec.exp + (dec.dbl ? 11'd1008 : 11'd112);
			end
		end
	end
endmodule

/* design/hfc_pack.sv */
// Third stage: special cases and result assembly.
module hfc_pack import hfc_pkg::*; (
	input  hfc_dec_t    dec,
	input  logic [10:0] exp_in,
	input  logic [9:0]  frac_in,
	input  logic        clamp,
	output hfc_out_t    out_item
);
	logic [15:0] h;
	logic [10:0] lo, hi;
	always_comb begin
		out_item = '0;
		h  = '0;
		lo = dec.dbl ? 11'd1008 : 11'd112;
		hi = dec.dbl ? 11'd1039 : 11'd143;
		if (dec.widen) begin
			out_item.half_is_nan = dec.emax && !dec.fzero;
			out_item.half_is_inf = dec.emax && dec.fzero;
			if (dec.hsub && dec.fzero) begin
				out_item.result = dec.dbl ? {dec.neg, 63'd0} : {32'd0, dec.neg, 31'd0};
			end else if (dec.emax && !dec.fzero) begin
				out_item.result = dec.dbl ? F64Nan : {32'd0, F32Nan};
			end else if (dec.emax) begin
				out_item.result = dec.dbl ? {dec.neg, 11'h7FF, 52'd0}
				                          : {32'd0, dec.neg, 8'hFF, 23'd0};
			end else if (dec.dbl) begin
				out_item.result = {dec.neg, exp_in, frac_in, 42'd0};
			end else begin
				out_item.result = {32'd0, dec.neg, exp_in[7:0], frac_in, 13'd0};
			end
		end else begin
			if (dec.emax && !dec.fzero) begin
				h = HalfNan;
			end else if (exp_in <= lo) begin
				h = {dec.neg, 15'd0};
			end else if (exp_in >= hi) begin
				h = {dec.neg, clamp ? HalfMaxf[14:0] : HalfInf[14:0]};
			end else begin
				h = {dec.neg, 5'(exp_in - lo), frac_in};
			end
			out_item.result      = {48'd0, h};
			out_item.half_is_nan = h[14:10] == 5'h1F && h[9:0] != 10'd0;
			out_item.half_is_inf = h[14:10] == 5'h1F && h[9:0] == 10'd0;
		end
	end
endmodule

/* test/tb_half_float_converter.sv */
// Self-checking testbench for the half float converter.
module tb_half_float_converter;
	import hfc_pkg::*;

	// Scoreboard: predicts each conversion when its beat is accepted and checks the
	// results in order as they come out of the pipeline.
	class conv_scoreboard;
		hfc_out_t pending[$];
		bit clamp_mode;
		int mismatches;

		function hfc_out_t convert(hfc_in_t beat);
			hfc_out_t r;
			logic [15:0] h;
			logic [10:0] ex;
			logic [63:0] ex64;
			logic [9:0] m;
			logic neg;
			logic [63:0] fr;
			int fbits;
			int ebias;
			logic [63:0] e;
			logic [63:0] emax;
			r = '0;
			if (beat.kind == KIND_H2S || beat.kind == KIND_H2D) begin
				h = beat.operand[15:0];
				fbits = (beat.kind == KIND_H2S) ? 23 : 52;
				ebias = (beat.kind == KIND_H2S) ? 127 : 1023;
				m = h[9:0];
				if (h[14:10] == 5'd0 && m == 0) begin
					r.result = (beat.kind == KIND_H2S) ? {32'd0, h[15], 31'd0} : {h[15], 63'd0};
				end else if (h[14:10] == 5'h1F) begin
					if (m != 0) begin
						r.result = (beat.kind == KIND_H2S) ? {32'd0, F32Nan} : F64Nan;
					end else begin
						r.result = (beat.kind == KIND_H2S) ? {32'd0, h[15], 31'h7F800000}
							: {h[15], 63'h7FF0000000000000};
					end
				end else begin
					if (h[14:10] == 5'd0) begin
						// Subnormal half: normalize so the leading one drops off.
						ex64 = ebias - 14;
						fr = {54'd0, m};
						while (fr[10] == 1'b0) begin
							fr = fr << 1;
							ex64 = ex64 - 1;
						end
						m = fr[9:0];
					end else begin
						ex64 = ebias - 15 + h[14:10];
					end
					if (beat.kind == KIND_H2S)
						r.result = {32'd0, h[15], ex64[7:0], m, 13'd0};
					else
						r.result = {h[15], ex64[10:0], m, 42'd0};
				end
			end else begin
				if (beat.kind == KIND_S2H) begin
					neg = beat.operand[31];
					e = beat.operand[30:23];
					fr = beat.operand[22:0];
					emax = 255; fbits = 23; ebias = 127;
				end else begin
					neg = beat.operand[63];
					e = beat.operand[62:52];
					fr = beat.operand[51:0];
					emax = 2047; fbits = 52; ebias = 1023;
				end
				if (e == emax && fr != 0)
					h = HalfNan;
				else if (e <= ebias - 15)
					h = {neg, 15'd0};
				else if (e >= ebias + 16)
					h = {neg, clamp_mode ? HalfMaxf[14:0] : HalfInf[14:0]};
				else begin
					ex = e - (ebias - 15);
					h = {neg, ex[4:0], 10'(fr >> (fbits - 10))};
				end
				r.result = {48'd0, h};
			end
			r.half_is_nan = (h[14:10] == 5'h1F) && (h[9:0] != 0);
			r.half_is_inf = (h[14:10] == 5'h1F) && (h[9:0] == 0);
			return r;
		endfunction

		function void note_input(hfc_in_t beat);
			pending.push_back(convert(beat));
		endfunction

		function void check_result(hfc_out_t got);
			hfc_out_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result %h", got);
				return;
			end
			want = pending.pop_front();
			if (got.result !== want.result || got.half_is_nan !== want.half_is_nan ||
					got.half_is_inf !== want.half_is_inf) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Mismatch: result %h/%h nan %b/%b inf %b/%b (expected/actual)",
						want.result, got.result, want.half_is_nan, got.half_is_nan,
						want.half_is_inf, got.half_is_inf);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	hfc_in_t operand_in = '0;
	logic done;
	hfc_out_t result_out;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_data = 1'b0;

	conv_scoreboard conversions = new();
	int sender_idle_pct = 0;
	longint cycle_count = 0;

	always #5 clk = ~clk;

	half_float_converter i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operand_in(operand_in), .done(done), .result_out(result_out),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// Results are sampled at the rising edge that ends their strobe cycle.
	always @(posedge clk) begin
		if (arst_n && done)
			conversions.check_result(result_out);
	end

	// Watchdog: its limit lies far beyond the slowest run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 200000) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Drives one beat, with a random idle gap in front of it, and holds it until the
	// block takes it. Start stays high across back-to-back beats.
	task automatic send_beat(input hfc_in_t beat);
		bit accepted;
		while ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		operand_in <= beat;
		accepted = 0;
		while (!accepted) begin
			@(posedge clk);
			accepted = !busy;
			if (accepted)
				conversions.note_input(beat);
			@(negedge clk);
		end
	endtask

	// Lets the pipeline drain until every expected result is in, then idles before returning.
	task automatic drain_pipeline();
		start <= 1'b0;
		while (conversions.pending.size() != 0)
			@(negedge clk);
		repeat (5) @(negedge clk);
	endtask

	// Writes the clamp register while the pipeline is empty.
	task automatic write_clamp(input bit value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		conversions.clamp_mode = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic hfc_in_t make_beat(kind_t k, logic [63:0] op);
		hfc_in_t b;
		b.kind = k;
		b.operand = op;
		return b;
	endfunction

	// Random operand weighted toward the interesting exponents of each source format.
	function automatic hfc_in_t random_beat();
		hfc_in_t b;
		logic [63:0] op;
		b.kind = kind_t'($urandom_range(3));
		op = {$urandom, $urandom};
		case ($urandom_range(3))
			0: ;
			1: begin
				if (b.kind == KIND_S2H) op[30:23] = 8'($urandom_range(108, 147));
				else if (b.kind == KIND_D2H) op[62:52] = 11'($urandom_range(1004, 1043));
				else op[14:10] = 5'($urandom_range(0, 1));
			end
			2: begin
				if (b.kind == KIND_S2H) op[30:23] = 8'hFF;
				else if (b.kind == KIND_D2H) op[62:52] = 11'h7FF;
				else op[14:10] = 5'h1F;
				// Clearing only the fraction turns the pattern into an infinity.
				if ($urandom_range(1)) begin
					if (b.kind == KIND_S2H) op[22:0] = '0;
					else if (b.kind == KIND_D2H) op[51:0] = '0;
					else op[9:0] = '0;
				end
			end
			default: begin
				if (b.kind == KIND_S2H) op[30:23] = 8'd0;
				else if (b.kind == KIND_D2H) op[62:52] = 11'd0;
				else op[14:0] = 15'($urandom_range(0, 1023));
			end
		endcase
		b.operand = op;
		return b;
	endfunction

	initial begin
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed beats: zeros, subnormals, infinities, NaNs and the narrowing bounds.
		send_beat(make_beat(KIND_H2S, 64'h0000));
		send_beat(make_beat(KIND_H2S, 64'hFFFF_FFFF_FFFF_8000));
		send_beat(make_beat(KIND_H2S, 64'h0001));
		send_beat(make_beat(KIND_H2D, 64'h83FF));
		send_beat(make_beat(KIND_H2S, 64'h7C00));
		send_beat(make_beat(KIND_H2D, 64'hFC00));
		send_beat(make_beat(KIND_H2S, 64'hFE01));
		send_beat(make_beat(KIND_H2D, 64'h7BFF));
		send_beat(make_beat(KIND_S2H, 64'h3800_0000));
		send_beat(make_beat(KIND_S2H, 64'hB880_0000));
		send_beat(make_beat(KIND_S2H, 64'h477F_FFFF));
		send_beat(make_beat(KIND_S2H, 64'hC780_0000));
		send_beat(make_beat(KIND_S2H, 64'hFF80_0000));
		send_beat(make_beat(KIND_S2H, 64'h7F80_0001));
		send_beat(make_beat(KIND_D2H, 64'h3F00_0000_0000_0000));
		send_beat(make_beat(KIND_D2H, 64'hBF10_0000_0000_0000));
		send_beat(make_beat(KIND_D2H, 64'h40EF_FFFF_FFFF_FFFF));
		send_beat(make_beat(KIND_D2H, 64'h40F0_0000_0000_0000));
		send_beat(make_beat(KIND_D2H, 64'h7FF0_0000_0000_0001));
		send_beat(make_beat(KIND_D2H, 64'hFFF0_0000_0000_0000));
		drain_pipeline();

		// Overflow cases, some of them repeated from above, with clamping on.
		write_clamp(1'b1);
		send_beat(make_beat(KIND_S2H, 64'hC780_0000));
		send_beat(make_beat(KIND_S2H, 64'h7F80_0000));
		send_beat(make_beat(KIND_D2H, 64'hFFF0_0000_0000_0000));
		send_beat(make_beat(KIND_D2H, 64'h7FEF_FFFF_FFFF_FFFF));
		drain_pipeline();

		// Random phases; each sets its idle rate and clamp setting.
		for (int phase = 0; phase < 4; phase++) begin
			write_clamp(phase[0]);
			sender_idle_pct = (phase == 1) ? 51 : (phase == 3) ? 18 : 0;
			for (int n = 0; n < 310; n++)
				send_beat(random_beat());
			drain_pipeline();
		end

		if (conversions.mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule

/* sim.f */
design/hfc_pkg.sv
design/hfc_decode.sv
design/hfc_norm.sv
design/hfc_pack.sv
design/half_float_converter.sv
test/tb_half_float_converter.sv
